// File: hdl/ficc_pkg.sv
// shared types, constants and register codes for the flat index / coordinate converter
`default_nettype none
package ficc_pkg;

  localparam int unsigned FLAT_W      = 48;
  localparam int unsigned FLAT_IW     = $clog2(FLAT_W);
  localparam int unsigned DIM_W       = 12;
  localparam int unsigned FIELD_DIMS  = 4;
  localparam int unsigned NDIM_W      = 3;
  localparam int unsigned MAX_DIMS_DEF = 4;
  localparam int unsigned QBITS       = 4;
  localparam int unsigned DIV_STEPS   = FLAT_W / QBITS;
  localparam int unsigned NUM_STAGES  = FIELD_DIMS * DIV_STEPS;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = FLAT_W + FIELD_DIMS * DIM_W;
  localparam int unsigned OUT_BITS    = FLAT_W + FIELD_DIMS * DIM_W + 2;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_DIMS   = 3'd0,
    REG_DIM_SIZE_0 = 3'd1,
    REG_DIM_SIZE_1 = 3'd2,
    REG_DIM_SIZE_2 = 3'd3,
    REG_DIM_SIZE_3 = 3'd4
  } reg_idx_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_COORD = 2'd2;

  typedef logic [FIELD_DIMS-1:0][DIM_W-1:0] dims_t;

  typedef struct packed {
    logic              kind;
    logic [FLAT_W-1:0] num;
    logic [DIM_W-1:0]  rem;
    dims_t             coord;
    dims_t             cin;
    logic [FLAT_W-1:0] acc;
    logic              err_rav;
    logic              err_zero;
  } pipe_t;

endpackage
`default_nettype wire

// File: hdl/flat_index_coordinate_convert_core.sv
// top level: row-major flat index <-> coordinate converter pipeline
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: flat_index, coord_in_0..3; s_tuser: kind
//  m_*      out  m_tvalid/m_tready    m_tdata: flat_index_out, coord_out_0..3, error_code
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// one request per cycle while m_* does not stall; stages: input stage, 48 division
// slices of 4 quotient bits each, 12 per dimension, then the output register
// the division slice chain sets the latency; ravel horner steps ride in stages 1..3
// rst is synchronous: pipeline and output empty, num_dims 1, all sizes 1
// a stall at m_* fills the skid entry, then the whole pipeline holds
`default_nettype none
module flat_index_coordinate_convert_core
  import ficc_pkg::*;
#(
  parameter int unsigned MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // flat_index, coord_in_0, coord_in_1, coord_in_2, coord_in_3
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // flat_index_out, coord_out_0..3, error_code, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  localparam int unsigned USE_DIMS = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

  // configuration registers
  logic [NDIM_W-1:0] num_dims;
  dims_t             dim_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= NDIM_W'(1);
      for (int i = 0; i < int'(FIELD_DIMS); i++) dim_size[i] <= DIM_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_DIMS:   num_dims    <= cfg_data[NDIM_W-1:0];
        REG_DIM_SIZE_0: dim_size[0] <= cfg_data;
        REG_DIM_SIZE_1: dim_size[1] <= cfg_data;
        REG_DIM_SIZE_2: dim_size[2] <= cfg_data;
        REG_DIM_SIZE_3: dim_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // dimensions in use, zero counts as one, capped
  logic [NDIM_W-1:0] n_used;
  dims_t             dim_eff;   // unused dims act as size one

  always_comb begin
    n_used = num_dims;
    if (n_used == '0) n_used = NDIM_W'(1);
    if (n_used > NDIM_W'(USE_DIMS)) n_used = NDIM_W'(USE_DIMS);
    for (int i = 0; i < int'(FIELD_DIMS); i++) begin
      dim_eff[i] = (NDIM_W'(i) < n_used) ? dim_size[i] : DIM_W'(1);
    end
  end

  // pipeline
  logic  advance;
  logic  pipe_valid [0:NUM_STAGES];
  pipe_t pipe       [0:NUM_STAGES];
  pipe_t stage_next [0:NUM_STAGES-1];
  pipe_t first;

  assign s_tready = advance;

  // input stage: unpack, mask unused coordinates, ravel range checks
  always_comb begin
    first          = '0;
    first.kind     = s_tuser;
    first.num      = s_tdata[FLAT_W-1:0];
    first.err_rav  = 1'b0;
    first.err_zero = 1'b0;
    for (int i = 0; i < int'(FIELD_DIMS); i++) begin
      if (NDIM_W'(i) < n_used) begin
        first.cin[i] = s_tdata[FLAT_W + i*DIM_W +: DIM_W];
        if (dim_size[i] == '0) first.err_zero = 1'b1;
        if (dim_size[i] == '0 || first.cin[i] >= dim_size[i]) first.err_rav = 1'b1;
      end
    end
    // single dimension passes coord 0 through unchecked
    if (n_used == NDIM_W'(1)) first.err_rav = 1'b0;
    first.acc = {{(FLAT_W-DIM_W){1'b0}}, first.cin[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= int'(NUM_STAGES); k++) pipe_valid[k] <= 1'b0;
    end else if (advance) begin
      pipe_valid[0] <= s_tvalid;
      for (int k = 0; k < int'(NUM_STAGES); k++) pipe_valid[k+1] <= pipe_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pipe[0] <= first;
      for (int k = 0; k < int'(NUM_STAGES); k++) pipe[k+1] <= stage_next[k];
    end
  end

  // division slices: last dimension first, 12 slices per dimension
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam int unsigned DIM  = FIELD_DIMS - 1 - k / DIV_STEPS;
    localparam int unsigned STEP = k % DIV_STEPS;
    pipe_t div_out;

    ficc_div_step #(.DIM(DIM), .STEP(STEP)) u_div (
      .din     (pipe[k]),
      .divisor (dim_eff[DIM]),
      .dout    (div_out)
    );

    if (k >= 1 && k < FIELD_DIMS) begin : g_horner
      logic [FLAT_W-1:0] acc_new;
      ficc_horner u_horner (
        .acc_in  (pipe[k].acc),
        .size    (dim_eff[k]),
        .coord   (pipe[k].cin[k]),
        .acc_out (acc_new)
      );
      always_comb begin
        stage_next[k]     = div_out;
        stage_next[k].acc = acc_new;
      end
    end else begin : g_pass
      assign stage_next[k] = div_out;
    end
  end

  // final result: range check of the leftover quotient, zero on error
  pipe_t                  last;
  logic                   err_idx;
  logic [FLAT_W-1:0]      flat_res;
  dims_t                  coord_res;
  logic [1:0]             err_res;
  logic [OUT_TDATA_W-1:0] result;

  assign last = pipe[NUM_STAGES];

  always_comb begin
    err_idx   = !last.kind && (last.err_zero || last.num != '0);
    flat_res  = (last.kind && !last.err_rav) ? last.acc : '0;
    coord_res = (!last.kind && !err_idx) ? last.coord : '0;
    if (last.kind) err_res = last.err_rav ? ERR_COORD : ERR_NONE;
    else           err_res = err_idx ? ERR_INDEX : ERR_NONE;
    result = '0;
    result[OUT_BITS-1:0] = {err_res, coord_res, flat_res};
  end

  ficc_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pipe_valid[NUM_STAGES]),
    .in_data  (result),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// File: hdl/ficc_div_step.sv
// one restoring division slice: QBITS quotient bits of the running index per stage
`default_nettype none
module ficc_div_step
  import ficc_pkg::*;
#(
  parameter int unsigned DIM  = 0,
  parameter int unsigned STEP = 0
) (
  input  pipe_t            din,
  input  logic [DIM_W-1:0] divisor,
  output pipe_t            dout
);

  logic [DIM_W:0]    r;
  logic [FLAT_W-1:0] num;
  logic [FLAT_IW-1:0] pos;

  always_comb begin
    r   = {1'b0, din.rem};
    num = din.num;
    pos = '0;
    for (int b = 0; b < int'(QBITS); b++) begin
      pos = FLAT_IW'(FLAT_W - 1 - STEP * QBITS - b);
      r   = {r[DIM_W-1:0], num[pos]};
      if (r >= {1'b0, divisor}) begin
        r        = r - {1'b0, divisor};
        num[pos] = 1'b1;
      end else begin
        num[pos] = 1'b0;
      end
    end
    dout     = din;
    dout.num = num;
    // last slice of a dimension: remainder is the coordinate
    if (STEP == DIV_STEPS - 1) begin
      dout.coord[DIM] = r[DIM_W-1:0];
      dout.rem        = '0;
    end else begin
      dout.rem = r[DIM_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/ficc_horner.sv
// one horner step of the ravel sum: acc * size + coordinate
`default_nettype none
module ficc_horner
  import ficc_pkg::*;
(
  input  logic [FLAT_W-1:0] acc_in,
  input  logic [DIM_W-1:0]  size,
  input  logic [DIM_W-1:0]  coord,
  output logic [FLAT_W-1:0] acc_out
);

  logic [FLAT_W+DIM_W-1:0] prod;

  assign prod    = acc_in * size;
  assign acc_out = prod[FLAT_W-1:0] + {{(FLAT_W-DIM_W){1'b0}}, coord};

endmodule
`default_nettype wire

// File: hdl/ficc_out_skid.sv
// output register with one skid entry
`default_nettype none
module ficc_out_skid
  import ficc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [OUT_TDATA_W-1:0] in_data,
  output logic                   advance,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic                   skid_valid;
  logic [OUT_TDATA_W-1:0] skid_data;

  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tdata    <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
      m_tdata  <= in_data;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= in_data;
    end
  end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the flat index / coordinate converter core
`timescale 1ns / 1ps
module tb_top;
  import ficc_pkg::*;

  localparam int unsigned LATENCY = 50;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 1650;

  // one conversion request as the block sees it
  typedef struct packed {
    logic              kind;
    logic [FLAT_W-1:0] flat;
    dims_t             coord;
  } conv_req_t;

  // one conversion answer, packed as on m_tdata (error_code on top)
  typedef struct packed {
    logic [1:0]        err;
    dims_t             coord;
    logic [FLAT_W-1:0] flat;
  } conv_rsp_t;

  // directed row: request plus optional hand-typed answer
  typedef struct {
    conv_req_t req;
    bit        typed;
    conv_rsp_t rsp;
  } vec_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]       cfg_data = '0;

  // predictor's copy of the shape registers
  logic [NDIM_W-1:0] shape_ndims;
  dims_t             shape_size;

  conv_rsp_t pending_rsp[$];
  int  err_count = 0;
  int  idle_cycles = 0;
  bit  hold_off_req = 1'b0;
  bit  feed_done = 1'b0;

  always #1 clk = ~clk;

  flat_index_coordinate_convert_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // row-major conversion under the current shape
  function automatic conv_rsp_t convert_index(conv_req_t r);
    conv_rsp_t  o;
    int unsigned n;
    logic [63:0] total, idx, acc, stride, d, c;
    o = '0;
    n = shape_ndims;
    if (n == 0) n = 1;
    if (n > MAX_DIMS_DEF) n = MAX_DIMS_DEF;
    if (r.kind == 1'b0) begin
      idx = {16'd0, r.flat};
      total = 64'd1;
      for (int i = 0; i < n; i++) total = total * shape_size[i];
      if (idx >= total) begin
        o.err = ERR_INDEX;
      end else begin
        for (int i = n - 1; i >= 0; i--) begin
          d = shape_size[i];
          o.coord[i] = DIM_W'(idx % d);
          idx = idx / d;
        end
      end
    end else if (n == 1) begin
      o.flat = FLAT_W'(r.coord[0]);
    end else begin
      acc = 0;
      stride = 1;
      for (int i = n - 1; i >= 0; i--) begin
        d = shape_size[i];
        c = r.coord[i];
        if (d == 0 || c >= d) begin
          o.err = ERR_COORD;
          break;
        end
        acc = acc + c * stride;
        stride = stride * d;
      end
      if (o.err == ERR_NONE) o.flat = FLAT_W'(acc);
    end
    return o;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_DIMS) shape_ndims = val[NDIM_W-1:0];
    else shape_size[idx - 1] = val;
    @(posedge clk);
  endtask

  task automatic set_shape(int unsigned nd, int unsigned s0, int unsigned s1,
                           int unsigned s2, int unsigned s3);
    write_reg(REG_NUM_DIMS, DIM_W'(nd));
    write_reg(REG_DIM_SIZE_0, DIM_W'(s0));
    write_reg(REG_DIM_SIZE_1, DIM_W'(s1));
    write_reg(REG_DIM_SIZE_2, DIM_W'(s2));
    write_reg(REG_DIM_SIZE_3, DIM_W'(s3));
  endtask

  // wait for the pipe to drain before a register write
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // send one request with an occasional gap ahead of it
  task automatic send_request(conv_req_t r, bit typed, conv_rsp_t want);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < 70) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.coord, r.flat};
    s_tuser  <= r.kind;
    do @(posedge clk); while (!s_tready);
    pending_rsp.insert(pending_rsp.size(), typed ? want : convert_index(r));
  endtask

  // random request biased toward in-range values for the current shape
  function automatic conv_req_t random_request();
    conv_req_t r;
    logic [63:0] total;
    int unsigned n;
    n = shape_ndims == 0 ? 1 : (shape_ndims > 4 ? 4 : shape_ndims);
    r.kind = 1'($urandom_range(0, 1));
    total = 1;
    for (int i = 0; i < n; i++) total = total * shape_size[i];
    r.flat = FLAT_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 9) < 8 && total != 0)
      r.flat = FLAT_W'({$urandom(), $urandom()} % total);
    for (int i = 0; i < FIELD_DIMS; i++) begin
      r.coord[i] = DIM_W'($urandom());
      if ($urandom_range(0, 9) < 8 && shape_size[i] != 0)
        r.coord[i] = DIM_W'($urandom() % shape_size[i]);
    end
    return r;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned n;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end
      n = $urandom_range(0, 99);
      m_tready <= (n >= 25);
      if (n < 3) begin
        repeat ($urandom_range(10, 80)) @(posedge clk);
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // answer checker
  always @(posedge clk) begin
    conv_rsp_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected answer %h", $time, got);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.flat != want.flat) begin
          $display("%0t: flat_index_out exp %h got %h", $time, want.flat, got.flat);
          err_count++;
        end
        for (int i = 0; i < FIELD_DIMS; i++)
          if (got.coord[i] != want.coord[i]) begin
            $display("%0t: coord_out_%0d exp %h got %h", $time, i,
                     want.coord[i], got.coord[i]);
            err_count++;
          end
        if (got.err != want.err) begin
          $display("%0t: error_code exp %0d got %0d", $time, want.err, got.err);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    vec_row_t  vecs[$];
    vec_row_t  v;
    conv_rsp_t none;
    int        sent;
    none = '0;
    shape_ndims = 3'd1;
    shape_size = {DIM_W'(1), DIM_W'(1), DIM_W'(1), DIM_W'(1)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape: one dimension of size 1
    v.req = '{kind: 1'b0, flat: '0, coord: '0};
    v.typed = 1; v.rsp = none; vecs.insert(vecs.size(), v);
    v.req = '{kind: 1'b0, flat: 48'd1, coord: '0};
    v.typed = 1; v.rsp = none; v.rsp.err = ERR_INDEX; vecs.insert(vecs.size(), v);
    v.req = '{kind: 1'b1, flat: '1, coord: {4{12'hfff}}};
    v.typed = 1; v.rsp = none; v.rsp.flat = 48'hfff; vecs.insert(vecs.size(), v);
    foreach (vecs[i]) send_request(vecs[i].req, vecs[i].typed, vecs[i].rsp);
    vecs.delete();
    drain_pipe();

    // full four-dim shape at the extremes
    set_shape(4, 4095, 4095, 4095, 4095);
    v.typed = 0;
    v.req = '{kind: 1'b0, flat: '1, coord: '0}; vecs.insert(vecs.size(), v);
    v.req = '{kind: 1'b0, flat: 48'hfffe_ffff_ffff, coord: '0}; vecs.insert(vecs.size(), v);
    v.req = '{kind: 1'b1, flat: '0, coord: {4{12'hffe}}}; vecs.insert(vecs.size(), v);
    v.req = '{kind: 1'b1, flat: '0, coord: {4{12'hfff}}};
    v.typed = 1; v.rsp = none; v.rsp.err = ERR_COORD; vecs.insert(vecs.size(), v);
    v.req = '{kind: 1'b1, flat: '0, coord: '0};
    v.typed = 1; v.rsp = none; vecs.insert(vecs.size(), v);
    foreach (vecs[i]) send_request(vecs[i].req, vecs[i].typed, vecs[i].rsp);
    vecs.delete();
    drain_pipe();

    // zero-sized dimension
    set_shape(3, 5, 0, 7, 9);
    v.typed = 1; v.rsp = none; v.rsp.err = ERR_INDEX;
    v.req = '{kind: 1'b0, flat: '0, coord: '0}; vecs.insert(vecs.size(), v);
    v.rsp.err = ERR_COORD;
    v.req = '{kind: 1'b1, flat: '0, coord: '0}; vecs.insert(vecs.size(), v);
    foreach (vecs[i]) send_request(vecs[i].req, vecs[i].typed, vecs[i].rsp);
    vecs.delete();
    drain_pipe();

    // num_dims zero behaves as one, above four saturates
    set_shape(0, 10, 3, 3, 3);
    send_request('{kind: 1'b0, flat: 48'd9, coord: '0}, 0, none);
    send_request('{kind: 1'b1, flat: '0, coord: {12'd7, 12'd7, 12'd7, 12'd4000}}, 0, none);
    drain_pipe();
    write_reg(REG_NUM_DIMS, 12'd7);
    send_request('{kind: 1'b0, flat: 48'd80, coord: '0}, 0, none);
    send_request('{kind: 1'b0, flat: 48'd269, coord: '0}, 0, none);
    send_request('{kind: 1'b1, flat: '0, coord: {12'd2, 12'd2, 12'd2, 12'd9}}, 0, none);
    drain_pipe();

    // random phases, each with a fresh shape
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      int unsigned nd, hi;
      nd = $urandom_range(0, 7);
      hi = ($urandom_range(0, 4) == 0) ? 4095 : 16;
      set_shape(nd, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, hi),
                $urandom_range(1, hi), $urandom_range(1, hi),
                $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, hi));
      for (int k = 0; k < 150; k++) begin
        // long receiver hold-off while requests keep coming
        if (sent == 400) hold_off_req = 1'b1;
        send_request(random_request(), 0, none);
        sent++;
      end
      drain_pipe();
    end

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
